// ----- hdl/afl_pkg.sv -----
// Shared widths, register codes, reset values and the level result type.
`default_nettype none
package afl_pkg;

	// field widths
	localparam int SAMPLE_W = 12;
	localparam int THR_W    = 12;
	localparam int DUTY_W   = 10;
	localparam int LEVEL_W  = 2;
	localparam int TEMP_W   = 12;
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 12;

	// scale: full-scale code maps to 330.0 degrees
	localparam int FULL_CODE   = 4095;
	localparam int FULL_TENTHS = 3300;
	localparam int TENTHS_W    = 12;
	localparam int DUTY_MAX    = 1000;

	// register indexes
	localparam logic [IDX_W-1:0] REG_RISE_MID  = 3'd0;
	localparam logic [IDX_W-1:0] REG_FALL_LOW  = 3'd1;
	localparam logic [IDX_W-1:0] REG_RISE_HIGH = 3'd2;
	localparam logic [IDX_W-1:0] REG_FALL_MID  = 3'd3;
	localparam logic [IDX_W-1:0] REG_DUTY_LOW  = 3'd4;
	localparam logic [IDX_W-1:0] REG_DUTY_MID  = 3'd5;
	localparam logic [IDX_W-1:0] REG_DUTY_HIGH = 3'd6;

	// register reset values
	localparam int RST_RISE_MID  = 255;
	localparam int RST_FALL_LOW  = 245;
	localparam int RST_RISE_HIGH = 305;
	localparam int RST_FALL_MID  = 295;
	localparam logic [DUTY_W-1:0] RST_DUTY_LOW  = 10'd250;
	localparam logic [DUTY_W-1:0] RST_DUTY_MID  = 10'd550;
	localparam logic [DUTY_W-1:0] RST_DUTY_HIGH = 10'd900;

	// fan levels
	localparam logic [LEVEL_W-1:0] LVL_LOW  = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_MID  = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_HIGH = 2'd2;

	// level decision for one block
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [DUTY_W-1:0]  duty;
		logic               changed;
	} lvl_info_t;

endpackage
`default_nettype wire

// ----- hdl/averaged_fan_level_hysteresis_core.sv -----
// Top level: sample accumulator, block pipeline and result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_ready  | sample
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  result   | out_valid/out_ready  | fan_level, duty, temp_tenths, level_changed
//
// One sample is taken per cycle while in_ready is high; every AVG_SAMPLES-th sample closes a block.
// After the transfer of a block's last sample, the block moves through the sum,
// compare, quotient estimate and correction registers, and out_valid rises as the
// last of them is loaded; the first is loaded by that transfer.
// Each stage holds only when it is full and the stage after it is stalled,
// so samples keep flowing while a result waits on out_ready, until all four
// stages hold a block.
// Reset clears the sum, count, level and stage valids and loads the config registers with their reset values.
`default_nettype none
module averaged_fan_level_hysteresis_core #(
	parameter int AVG_SAMPLES = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [afl_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [afl_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [afl_pkg::DATA_W-1:0]    cfg_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [afl_pkg::LEVEL_W-1:0]        fan_level,
	output logic [afl_pkg::DUTY_W-1:0]         duty,
	output logic [afl_pkg::TEMP_W-1:0]         temp_tenths,
	output logic                               level_changed
);
	import afl_pkg::*;

	localparam int CNT_W = $clog2(AVG_SAMPLES);
	localparam int SUM_W = SAMPLE_W + CNT_W;
	localparam int LHS_W = SUM_W + TENTHS_W;
	localparam int SCL_W = THR_W + $clog2(FULL_CODE * AVG_SAMPLES + 1);

	logic [SCL_W-1:0]   rise_mid, fall_low, rise_high, fall_mid;
	logic [DUTY_W-1:0]  duty_low, duty_mid, duty_high;

	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [LEVEL_W-1:0] level_q;

	logic               v_s1, v_s2, v_s3;
	logic [SUM_W-1:0]   sum_s1;
	logic [LHS_W-1:0]   lhs_s2;
	lvl_info_t          info_s2, info_s3;

	logic [LHS_W-1:0]   lhs_c;
	lvl_info_t          info_c;
	logic [TEMP_W-1:0]  temp_c;
	logic [SUM_W-1:0]   sum_nxt;
	logic               in_xfer, last;
	logic               adv_out, adv_s3, adv_s2, adv_s1;

	afl_cfg #(.AVG_SAMPLES(AVG_SAMPLES)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rise_mid  (rise_mid),
		.fall_low  (fall_low),
		.rise_high (rise_high),
		.fall_mid  (fall_mid),
		.duty_low  (duty_low),
		.duty_mid  (duty_mid),
		.duty_high (duty_high)
	);

	// stage advance chain, back from the result register
	assign adv_out  = !out_valid || out_ready;
	assign adv_s3   = !v_s3 || adv_out;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign in_xfer = in_valid && in_ready;
	assign last    = (cnt_q == CNT_W'(AVG_SAMPLES - 1));
	assign sum_nxt = sum_q + SUM_W'(sample);

	// block accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (in_xfer) begin
			if (last) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_nxt;
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// stage valids and fan level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
			level_q   <= LVL_LOW;
		end else begin
			if (adv_s1)  v_s1 <= in_xfer && last;
			if (adv_s2)  v_s2 <= v_s1;
			if (adv_s3)  v_s3 <= v_s2;
			if (adv_out) out_valid <= v_s3;
			if (adv_s2 && v_s1) level_q <= info_c.level;
		end
	end

	afl_hyst #(.AVG_SAMPLES(AVG_SAMPLES)) u_hyst (
		.sum       (sum_s1),
		.level     (level_q),
		.rise_mid  (rise_mid),
		.fall_low  (fall_low),
		.rise_high (rise_high),
		.fall_mid  (fall_mid),
		.duty_low  (duty_low),
		.duty_mid  (duty_mid),
		.duty_high (duty_high),
		.lhs       (lhs_c),
		.info      (info_c)
	);

	afl_div #(.AVG_SAMPLES(AVG_SAMPLES)) u_div (
		.clk  (clk),
		.ld   (adv_s3),
		.lhs  (lhs_s2),
		.temp (temp_c)
	);

	// payload stages
	always_ff @(posedge clk) begin
		if (adv_s1) sum_s1 <= sum_nxt;
		if (adv_s2) begin
			lhs_s2  <= lhs_c;
			info_s2 <= info_c;
		end
		if (adv_s3) info_s3 <= info_s2;
		if (adv_out) begin
			fan_level     <= info_s3.level;
			duty          <= info_s3.duty;
			level_changed <= info_s3.changed;
			temp_tenths   <= temp_c;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/afl_cfg.sv -----
// Configuration registers; thresholds are stored pre-scaled to block-sum units.
`default_nettype none
module afl_cfg #(
	parameter int AVG_SAMPLES = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [afl_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [afl_pkg::DATA_W-1:0]   cfg_data,
	output logic [afl_pkg::THR_W+$clog2(afl_pkg::FULL_CODE*AVG_SAMPLES+1)-1:0] rise_mid,
	output logic [afl_pkg::THR_W+$clog2(afl_pkg::FULL_CODE*AVG_SAMPLES+1)-1:0] fall_low,
	output logic [afl_pkg::THR_W+$clog2(afl_pkg::FULL_CODE*AVG_SAMPLES+1)-1:0] rise_high,
	output logic [afl_pkg::THR_W+$clog2(afl_pkg::FULL_CODE*AVG_SAMPLES+1)-1:0] fall_mid,
	output logic [afl_pkg::DUTY_W-1:0]        duty_low,
	output logic [afl_pkg::DUTY_W-1:0]        duty_mid,
	output logic [afl_pkg::DUTY_W-1:0]        duty_high
);
	import afl_pkg::*;

	localparam int DIV_FULL = FULL_CODE * AVG_SAMPLES;
	localparam int DF_W     = $clog2(DIV_FULL + 1);
	localparam int SCL_W    = THR_W + DF_W;

	logic [SCL_W-1:0] scaled;
	logic             wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;

	// threshold times 4095*N, one constant multiply on the write path
	assign scaled = SCL_W'(cfg_data[THR_W-1:0]) * SCL_W'(DIV_FULL);

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_mid  <= SCL_W'(RST_RISE_MID * DIV_FULL);
			fall_low  <= SCL_W'(RST_FALL_LOW * DIV_FULL);
			rise_high <= SCL_W'(RST_RISE_HIGH * DIV_FULL);
			fall_mid  <= SCL_W'(RST_FALL_MID * DIV_FULL);
			duty_low  <= RST_DUTY_LOW;
			duty_mid  <= RST_DUTY_MID;
			duty_high <= RST_DUTY_HIGH;
		end else if (wr) begin
			unique case (cfg_index)
				REG_RISE_MID:  rise_mid  <= scaled;
				REG_FALL_LOW:  fall_low  <= scaled;
				REG_RISE_HIGH: rise_high <= scaled;
				REG_FALL_MID:  fall_mid  <= scaled;
				REG_DUTY_LOW:  duty_low  <= cfg_data[DUTY_W-1:0];
				REG_DUTY_MID:  duty_mid  <= cfg_data[DUTY_W-1:0];
				REG_DUTY_HIGH: duty_high <= cfg_data[DUTY_W-1:0];
				default: ;     // unknown index ignored
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/afl_hyst.sv -----
// Block-sum scaling, threshold compares and the three-level hysteresis decision.
`default_nettype none
module afl_hyst #(
	parameter int AVG_SAMPLES = 8
) (
	input  wire logic [afl_pkg::SAMPLE_W+$clog2(AVG_SAMPLES)-1:0] sum,
	input  wire logic [afl_pkg::LEVEL_W-1:0]  level,
	input  wire logic [afl_pkg::THR_W+$clog2(afl_pkg::FULL_CODE*AVG_SAMPLES+1)-1:0] rise_mid,
	input  wire logic [afl_pkg::THR_W+$clog2(afl_pkg::FULL_CODE*AVG_SAMPLES+1)-1:0] fall_low,
	input  wire logic [afl_pkg::THR_W+$clog2(afl_pkg::FULL_CODE*AVG_SAMPLES+1)-1:0] rise_high,
	input  wire logic [afl_pkg::THR_W+$clog2(afl_pkg::FULL_CODE*AVG_SAMPLES+1)-1:0] fall_mid,
	input  wire logic [afl_pkg::DUTY_W-1:0]   duty_low,
	input  wire logic [afl_pkg::DUTY_W-1:0]   duty_mid,
	input  wire logic [afl_pkg::DUTY_W-1:0]   duty_high,
	output logic [afl_pkg::SAMPLE_W+$clog2(AVG_SAMPLES)+afl_pkg::TENTHS_W-1:0] lhs,
	output afl_pkg::lvl_info_t                info
);
	import afl_pkg::*;

	localparam int SUM_W = SAMPLE_W + $clog2(AVG_SAMPLES);
	localparam int LHS_W = SUM_W + TENTHS_W;
	localparam int SCL_W = THR_W + $clog2(FULL_CODE * AVG_SAMPLES + 1);
	localparam int CMP_W = (LHS_W > SCL_W) ? LHS_W : SCL_W;

	logic                ge_rm, ge_fl, ge_rh, ge_fm;
	logic [LEVEL_W-1:0]  nxt;
	logic [DUTY_W-1:0]   raw;

	// sum * 3300, compared exactly against pre-scaled thresholds
	assign lhs   = LHS_W'(sum) * LHS_W'(FULL_TENTHS);
	assign ge_rm = CMP_W'(lhs) >= CMP_W'(rise_mid);
	assign ge_fl = CMP_W'(lhs) >= CMP_W'(fall_low);
	assign ge_rh = CMP_W'(lhs) >= CMP_W'(rise_high);
	assign ge_fm = CMP_W'(lhs) >= CMP_W'(fall_mid);

	// next level; falling wins over rising at medium
	always_comb begin
		nxt = level;
		unique case (level)
			LVL_LOW: begin
				if (ge_rm) nxt = LVL_MID;
			end
			LVL_MID: begin
				if (!ge_fl)     nxt = LVL_LOW;
				else if (ge_rh) nxt = LVL_HIGH;
			end
			default: begin
				if (!ge_fm) nxt = LVL_MID;
			end
		endcase
	end

	// duty of the new level, saturated
	always_comb begin
		unique case (nxt)
			LVL_LOW: raw = duty_low;
			LVL_MID: raw = duty_mid;
			default: raw = duty_high;
		endcase
	end

	assign info.level   = nxt;
	assign info.duty    = (raw > DUTY_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : raw;
	assign info.changed = (nxt != level);

endmodule
`default_nettype wire

// ----- hdl/afl_div.sv -----
// Divide by 4095*N via reciprocal multiply, then one compare-and-correct step.
`default_nettype none
module afl_div #(
	parameter int AVG_SAMPLES = 8
) (
	input  wire logic clk,
	input  wire logic ld,
	input  wire logic [afl_pkg::SAMPLE_W+$clog2(AVG_SAMPLES)+afl_pkg::TENTHS_W-1:0] lhs,
	output logic [afl_pkg::TEMP_W-1:0] temp
);
	import afl_pkg::*;

	localparam int SUM_W    = SAMPLE_W + $clog2(AVG_SAMPLES);
	localparam int LHS_W    = SUM_W + TENTHS_W;
	localparam int DIV_FULL = FULL_CODE * AVG_SAMPLES;
	localparam int DF_W     = $clog2(DIV_FULL + 1);
	// lhs < 2**LHS_W, so the estimate is the quotient or one below it
	localparam longint RECIP = (longint'(1) << LHS_W) / DIV_FULL;
	localparam int RC_W     = $clog2(RECIP + 1);
	localparam int PR_W     = LHS_W + RC_W;
	localparam int QD_W     = TEMP_W + DF_W;

	logic [PR_W-1:0]   prod;
	logic [TEMP_W-1:0] q0_s3;
	logic [LHS_W-1:0]  lhs_s3;
	logic [QD_W-1:0]   qd;
	logic [LHS_W-1:0]  rem;

	// quotient estimate
	assign prod = PR_W'(lhs) * PR_W'(RECIP);

	always_ff @(posedge clk) begin
		if (ld) begin
			q0_s3  <= prod[LHS_W +: TEMP_W];
			lhs_s3 <= lhs;
		end
	end

	// remainder check, bump by one if still at or above the divisor
	assign qd   = QD_W'(q0_s3) * QD_W'(DIV_FULL);
	assign rem  = lhs_s3 - LHS_W'(qd);
	assign temp = (rem >= LHS_W'(DIV_FULL)) ? q0_s3 + TEMP_W'(1) : q0_s3;

endmodule
`default_nettype wire

// ----- tb/sv/afl_result_checker.sv -----
// Checker for the averaged fan level core: tracks transfers, predicts block results, compares.
`timescale 1ns / 100ps
module afl_result_checker #(
	parameter int BLOCK_LEN = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic [afl_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [afl_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [afl_pkg::DATA_W-1:0]    cfg_data,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic [afl_pkg::LEVEL_W-1:0]   fan_level,
	input  wire logic [afl_pkg::DUTY_W-1:0]    duty,
	input  wire logic [afl_pkg::TEMP_W-1:0]    temp_tenths,
	input  wire logic                          level_changed,
	input  wire logic                          wrap_up,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 blocks_checked,
	output int                                 moves_seen
);
	import afl_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [DUTY_W-1:0]  duty;
		logic [TEMP_W-1:0]  temp;
		logic               moved;
	} fan_report_t;

	// shadow of the register file
	logic [THR_W-1:0]   rise_mid_thr, fall_low_thr, rise_high_thr, fall_mid_thr;
	logic [DUTY_W-1:0]  duty_low_reg, duty_mid_reg, duty_high_reg;

	// accumulator and fan state
	logic [15:0]        block_sum;
	int                 block_fill;
	logic [LEVEL_W-1:0] fan_state;

	fan_report_t        awaited_reports [$];
	bit                 leftovers_counted;

	// exact compare: sum * 3300 >= thr * 4095 * BLOCK_LEN
	function automatic bit sum_reaches(input logic [15:0] sum, input logic [THR_W-1:0] thr);
		longint unsigned heat;
		longint unsigned bar;
		heat = 64'(sum);
		heat = heat * FULL_TENTHS;
		bar = 64'(thr);
		bar = bar * FULL_CODE * BLOCK_LEN;
		return heat >= bar;
	endfunction

	function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] d);
		return (d > DUTY_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : d;
	endfunction

	// hysteresis step for one closed block, at most one level per block
	function automatic fan_report_t settle_block(input logic [15:0] sum,
			input logic [LEVEL_W-1:0] prev);
		fan_report_t r;
		longint unsigned t;
		r.level = prev;
		case (prev)
		LVL_LOW: if (sum_reaches(sum, rise_mid_thr)) r.level = LVL_MID;
		LVL_MID: begin
			// falling to low wins over rising to high
			if (!sum_reaches(sum, fall_low_thr)) r.level = LVL_LOW;
			else if (sum_reaches(sum, rise_high_thr)) r.level = LVL_HIGH;
		end
		default: if (!sum_reaches(sum, fall_mid_thr)) r.level = LVL_MID;
		endcase
		case (r.level)
		LVL_LOW: r.duty = clamp_duty(duty_low_reg);
		LVL_MID: r.duty = clamp_duty(duty_mid_reg);
		default: r.duty = clamp_duty(duty_high_reg);
		endcase
		t = 64'(sum);
		t = (t * FULL_TENTHS) / (FULL_CODE * BLOCK_LEN);
		r.temp = TEMP_W'(t);
		r.moved = (r.level != prev);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fan_report_t got;
		fan_report_t want;
		if (!arst_n) begin
			rise_mid_thr  = THR_W'(RST_RISE_MID);
			fall_low_thr  = THR_W'(RST_FALL_LOW);
			rise_high_thr = THR_W'(RST_RISE_HIGH);
			fall_mid_thr  = THR_W'(RST_FALL_MID);
			duty_low_reg  = RST_DUTY_LOW;
			duty_mid_reg  = RST_DUTY_MID;
			duty_high_reg = RST_DUTY_HIGH;
			block_sum = '0;
			block_fill = 0;
			fan_state = LVL_LOW;
			awaited_reports.delete();
			pending = 0;
		end else begin
			// register write transfer; unknown indexes fall through
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_RISE_MID:  rise_mid_thr  = cfg_data[THR_W-1:0];
				REG_FALL_LOW:  fall_low_thr  = cfg_data[THR_W-1:0];
				REG_RISE_HIGH: rise_high_thr = cfg_data[THR_W-1:0];
				REG_FALL_MID:  fall_mid_thr  = cfg_data[THR_W-1:0];
				REG_DUTY_LOW:  duty_low_reg  = cfg_data[DUTY_W-1:0];
				REG_DUTY_MID:  duty_mid_reg  = cfg_data[DUTY_W-1:0];
				REG_DUTY_HIGH: duty_high_reg = cfg_data[DUTY_W-1:0];
				default: ;
				endcase
			end

			// result transfer against the oldest prediction
			if (out_valid && out_ready) begin
				got = {fan_level, duty, temp_tenths, level_changed};
				if (awaited_reports.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("[%0t] result with nothing awaited: level %0d duty %0d temp %0d changed %0b",
							$time, got.level, got.duty, got.temp, got.moved);
				end else begin
					want = awaited_reports.pop_front();
					blocks_checked++;
					if (got.level !== want.level || got.duty !== want.duty ||
							got.temp !== want.temp || got.moved !== want.moved) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("[%0t] block %0d differs: level %0d/%0d duty %0d/%0d temp %0d/%0d changed %0b/%0b (exp/got)",
								$time, blocks_checked, want.level, got.level, want.duty, got.duty,
								want.temp, got.temp, want.moved, got.moved);
					end
				end
			end

			// sample transfer; every BLOCK_LEN-th closes a block
			if (in_valid && in_ready) begin
				block_sum += 16'(sample);
				block_fill++;
				if (block_fill == BLOCK_LEN) begin
					want = settle_block(block_sum, fan_state);
					fan_state = want.level;
					if (want.moved) moves_seen++;
					awaited_reports.push_back(want);
					block_sum = '0;
					block_fill = 0;
				end
			end

			pending = awaited_reports.size();

			// end of run: anything still awaited never arrived
			if (wrap_up && !leftovers_counted) begin
				leftovers_counted = 1'b1;
				if (pending != 0) begin
					fail_count += pending;
					$display("%0d block results never arrived", pending);
				end
			end
		end
	end

endmodule

// ----- tb/sv/tb_averaged_fan_level_hysteresis_core.sv -----
// Top of the fan level core bench: clock, reset, sample and register stimulus, verdict.
`timescale 1ns / 100ps
module tb_averaged_fan_level_hysteresis_core;
	import afl_pkg::*;

	localparam int BLOCK_LEN      = 8;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int RANDOM_SAMPLES = 1300;
	localparam int SETTINGS_RUN   = 8;
	localparam int PHASE_BLOCKS   = RANDOM_SAMPLES / (BLOCK_LEN * SETTINGS_RUN);
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_STALL      = 20;
	localparam int FULL_SUM       = FULL_CODE * BLOCK_LEN;
	// index past the register file, writes to it must be dropped
	localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index;
	logic [DATA_W-1:0]   cfg_data;
	logic                out_valid;
	logic                out_ready;
	logic [LEVEL_W-1:0]  fan_level;
	logic [DUTY_W-1:0]   duty;
	logic [TEMP_W-1:0]   temp_tenths;
	logic                level_changed;
	logic                wrap_up;

	int fail_count;
	int pending;
	int blocks_checked;
	int moves_seen;
	int cycle_count = 0;
	int samples_sent;
	int settings_loaded;
	int burst_left;

	// current thresholds, used only to aim sample blocks at the edges
	int thr_now [REG_RISE_MID:REG_FALL_MID];

	rx_mode_t rx_mode = RX_OPEN;
	int       rx_timer = 0;
	int       stall_left = 0;

	averaged_fan_level_hysteresis_core #(
		.AVG_SAMPLES(BLOCK_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.fan_level(fan_level),
		.duty(duty),
		.temp_tenths(temp_tenths),
		.level_changed(level_changed)
	);

	afl_result_checker #(
		.BLOCK_LEN(BLOCK_LEN)
	) fan_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.fan_level(fan_level),
		.duty(duty),
		.temp_tenths(temp_tenths),
		.level_changed(level_changed),
		.wrap_up(wrap_up),
		.fail_count(fail_count),
		.pending(pending),
		.blocks_checked(blocks_checked),
		.moves_seen(moves_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped at cycle limit %0d", CYCLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// result side backpressure, switching to a randomly chosen style whenever its timer runs out
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
			RX_OPEN:     out_ready <= 1'b1;
			RX_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: out_ready <= (cycle_count % 3 == 0);
			default: begin
				if ($urandom_range(0, 9) == 0) begin
					out_ready <= 1'b0;
					stall_left <= $urandom_range(1, MAX_STALL);
				end else begin
					out_ready <= 1'b1;
				end
			end
			endcase
		end
		if (rx_timer == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(RX_OPEN, RX_BURSTY));
			rx_timer <= $urandom_range(50, 400);
		end else begin
			rx_timer <= rx_timer - 1;
		end
	end

	// one sample transfer; a used-up burst may be followed by a random gap
	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		samples_sent++;
		@(negedge clk);
	endtask

	// one block: aimed just around a threshold, uniform noise, or a flat level
	task automatic send_block();
		int vals [BLOCK_LEN];
		int pick;
		int target;
		int jitter;
		int delta;
		int flat;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			jitter = $urandom_range(0, 8);
			target = thr_now[$urandom_range(REG_RISE_MID, REG_FALL_MID)];
			target = (target * FULL_SUM + FULL_TENTHS - 1) / FULL_TENTHS + jitter - 4;
			if (target < 0) target = 0;
			if (target > FULL_SUM) target = FULL_SUM;
			for (int i = 0; i < BLOCK_LEN; i++)
				vals[i] = target / BLOCK_LEN + ((i < target % BLOCK_LEN) ? 1 : 0);
			// shuffle weight between neighbors, keeping the sum
			for (int i = 0; i < BLOCK_LEN - 1; i++) begin
				delta = $urandom_range(0, 700);
				if (vals[i] + delta <= FULL_CODE && vals[i + 1] >= delta) begin
					vals[i] += delta;
					vals[i + 1] -= delta;
				end else if (vals[i + 1] + delta <= FULL_CODE && vals[i] >= delta) begin
					vals[i] -= delta;
					vals[i + 1] += delta;
				end
			end
		end else if (pick < 85) begin
			foreach (vals[i]) vals[i] = $urandom_range(0, FULL_CODE);
		end else begin
			case ($urandom_range(0, 2))
			0: flat = 0;
			1: flat = FULL_CODE;
			default: flat = $urandom_range(0, FULL_CODE);
			endcase
			foreach (vals[i]) vals[i] = flat;
		end
		foreach (vals[i]) send_sample(SAMPLE_W'(vals[i]));
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= DATA_W'(data);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// full register set, optionally preceded by a write to the spare index
	task automatic load_all(input int rm, input int fl, input int rh, input int fm,
			input int dl, input int dm, input int dh, input bit poke_spare);
		if (poke_spare) write_reg(REG_SPARE, $urandom_range(0, 4095));
		write_reg(REG_RISE_MID, rm);
		write_reg(REG_FALL_LOW, fl);
		write_reg(REG_RISE_HIGH, rh);
		write_reg(REG_FALL_MID, fm);
		write_reg(REG_DUTY_LOW, dl);
		write_reg(REG_DUTY_MID, dm);
		write_reg(REG_DUTY_HIGH, dh);
		cfg_valid <= 1'b0;
		thr_now[REG_RISE_MID] = rm % (1 << THR_W);
		thr_now[REG_FALL_LOW] = fl % (1 << THR_W);
		thr_now[REG_RISE_HIGH] = rh % (1 << THR_W);
		thr_now[REG_FALL_MID] = fm % (1 << THR_W);
		settings_loaded++;
	endtask

	task automatic run_blocks(input int count);
		repeat (count) send_block();
	endtask

	// idle the sample side, wait out every awaited result and the pipeline tail
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_RISE_MID;
		cfg_data = '0;
		out_ready = 1'b0;
		wrap_up = 1'b0;
		burst_left = 0;
		samples_sent = 0;
		settings_loaded = 1;
		thr_now[REG_RISE_MID] = RST_RISE_MID;
		thr_now[REG_FALL_LOW] = RST_FALL_LOW;
		thr_now[REG_RISE_HIGH] = RST_RISE_HIGH;
		thr_now[REG_FALL_MID] = RST_FALL_MID;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: full scale climbs one level per block, zero drops one
		repeat (2 * BLOCK_LEN) send_sample(SAMPLE_W'(FULL_CODE));
		repeat (BLOCK_LEN) send_sample('0);
		run_blocks(PHASE_BLOCKS);

		// random thresholds in range, random duty data including upper bits
		drain();
		load_all($urandom_range(0, 3300), $urandom_range(0, 3300), $urandom_range(0, 3300),
			$urandom_range(0, 3300), $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095), 1'b0);
		run_blocks(PHASE_BLOCKS);

		// threshold extremes, duty at zero, at the cap and past it
		drain();
		load_all(0, 0, 3300, 3300, 0, DUTY_MAX, 'h3FF, 1'b0);
		run_blocks(PHASE_BLOCKS);

		// fall-to-low above range always applies, so medium keeps dropping back
		drain();
		load_all(0, 4095, 0, 0, 'hFFF, 'hC00, DUTY_MAX + 1, 1'b0);
		run_blocks(PHASE_BLOCKS);

		// fall-to-low above rise-to-high; thresholds where the compare can tie exactly
		drain();
		load_all(550, 2200, 1100, 1650, 'h555, 'hAAA, DUTY_MAX, 1'b1);
		run_blocks(PHASE_BLOCKS);

		// fall-to-mid above range: high never holds
		drain();
		load_all(200, 100, 400, 3500, $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095), 1'b0);
		run_blocks(PHASE_BLOCKS);

		// rise-to-high above range: high never reached
		drain();
		load_all(300, 250, 4095, 295, $urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 1023), 1'b1);
		run_blocks(PHASE_BLOCKS);

		// back to the power-up settings
		drain();
		load_all(RST_RISE_MID, RST_FALL_LOW, RST_RISE_HIGH, RST_FALL_MID,
			RST_DUTY_LOW, RST_DUTY_MID, RST_DUTY_HIGH, 1'b0);
		run_blocks(PHASE_BLOCKS);

		drain();
		wrap_up <= 1'b1;
		@(negedge clk);

		$display("Covered %0d samples under %0d register settings in %0d cycles",
			samples_sent, settings_loaded, cycle_count);
		$display("Compared %0d block results, %0d of them moved the fan level",
			blocks_checked, moves_seen);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
